>>> rtl/stl_pkg.sv
// Shared types, token kind codes and keyword table for the source tokenizer.
// Used by the front scanner, the bundle queue and the back emitter.
package stl_pkg;

   localparam int OFFSET_BITS_DEFAULT = 24;
   localparam int MAX_KEYWORD_CHARS_DEFAULT = 7;
   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;
   localparam int QUEUE_CNT_BITS = 3;
   localparam int KW_CODE_BITS = 64;

   localparam logic [6:0] KD_EOF = 7'd0;
   localparam logic [6:0] KD_ERROR = 7'd1;
   localparam logic [6:0] KD_IDENT = 7'd2;
   localparam logic [6:0] KD_NUMBER = 7'd3;
   localparam logic [6:0] KD_STRING = 7'd4;
   localparam logic [6:0] KD_LPAREN = 7'd45;
   localparam logic [6:0] KD_RPAREN = 7'd46;
   localparam logic [6:0] KD_LBRACE = 7'd47;
   localparam logic [6:0] KD_RBRACE = 7'd48;
   localparam logic [6:0] KD_LBRACKET = 7'd49;
   localparam logic [6:0] KD_RBRACKET = 7'd50;
   localparam logic [6:0] KD_SEMI = 7'd51;
   localparam logic [6:0] KD_COLON = 7'd52;
   localparam logic [6:0] KD_COMMA = 7'd53;
   localparam logic [6:0] KD_DOT = 7'd54;
   localparam logic [6:0] KD_PLUS = 7'd55;
   localparam logic [6:0] KD_MINUS = 7'd56;
   localparam logic [6:0] KD_STAR = 7'd57;
   localparam logic [6:0] KD_SLASH = 7'd58;
   localparam logic [6:0] KD_PERCENT = 7'd59;
   localparam logic [6:0] KD_EQ = 7'd60;
   localparam logic [6:0] KD_EQEQ = 7'd61;
   localparam logic [6:0] KD_BANG = 7'd62;
   localparam logic [6:0] KD_BANGEQ = 7'd63;
   localparam logic [6:0] KD_LT = 7'd64;
   localparam logic [6:0] KD_LE = 7'd65;
   localparam logic [6:0] KD_GT = 7'd66;
   localparam logic [6:0] KD_GE = 7'd67;
   localparam logic [6:0] KD_ARROW = 7'd68;
   localparam logic [6:0] KD_FATARROW = 7'd69;
   localparam logic [6:0] KD_PIPE = 7'd70;
   localparam logic [6:0] KD_AMP = 7'd71;
   localparam logic [6:0] KD_DCOLON = 7'd72;

   typedef struct packed {
      logic [6:0]  kind;
      logic [23:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic [15:0] col;
   } tok_type;

   typedef struct packed {
      logic [1:0]                       cnt;
      logic [KW_CODE_BITS-1:0]          kw_code;
      tok_type [MAX_RESULTS-1:0]        tok;
   } bundle_type;

   function automatic logic [6:0] kw_kind(input logic [KW_CODE_BITS-1:0] code);
      logic [6:0] k;
      unique case (code)
         "fn":      k = 7'd8;
         "as":      k = 7'd36;
         "in":      k = 7'd28;
         "let":     k = 7'd18;
         "var":     k = 7'd19;
         "use":     k = 7'd34;
         "for":     k = 7'd27;
         "try":     k = 7'd40;
         "tag":     k = 7'd16;
         "else":    k = 7'd24;
         "data":    k = 7'd9;
         "each":    k = 7'd26;
         "loop":    k = 7'd29;
         "next":    k = 7'd33;
         "open":    k = 7'd20;
         "flow":    k = 7'd13;
         "from":    k = 7'd35;
         "true":    k = 7'd5;
         "null":    k = 7'd7;
         "yield":   k = 7'd31;
         "abort":   k = 7'd32;
         "check":   k = 7'd23;
         "match":   k = 7'd25;
         "while":   k = 7'd30;
         "cases":   k = 7'd10;
         "rules":   k = 7'd11;
         "skill":   k = 7'd12;
         "space":   k = 7'd14;
         "given":   k = 7'd15;
         "alias":   k = 7'd17;
         "async":   k = 7'd37;
         "await":   k = 7'd38;
         "spawn":   k = 7'd39;
         "catch":   k = 7'd41;
         "false":   k = 7'd6;
         "expose":  k = 7'd21;
         "ensure":  k = 7'd43;
         "assert":  k = 7'd44;
         "require": k = 7'd42;
         "derives": k = 7'd22;
         default:   k = KD_IDENT;
      endcase
      return k;
   endfunction

endpackage

>>> rtl/stl_front.sv
// Front scanner: accepts one source beat per cycle while the bundle queue has room, tracks position and
// scan mode, and pushes a bundle of up to three raw tokens. Uses stl_pkg.
module stl_front #(
   parameter int OFFSET_BITS = 24,
   parameter int MAX_KEYWORD_CHARS = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_char_byte,
   input  logic                req_end_of_source,
   input  logic                q_not_full,
   output logic                push,
   output stl_pkg::bundle_type push_bundle
);
   import stl_pkg::*;

   localparam int KB_BITS = MAX_KEYWORD_CHARS * 8;

   typedef enum logic [3:0] {
      M_IDLE, M_WORD, M_INT, M_DOT, M_FRAC, M_STR, M_CMT, M_SLASH,
      M_COLON, M_MINUS, M_EQ, M_BANG, M_LT, M_GT
   } mode_type;

   typedef struct packed {
      mode_type               mode;
      logic [KB_BITS-1:0]     kb;
      logic [15:0]            pl;
      logic [OFFSET_BITS-1:0] ps;
      logic [OFFSET_BITS-1:0] p;
      logic [15:0]            ln;
      logic [15:0]            cl;
   } scan_type;

   typedef struct packed {
      scan_type s;
      logic     v;
      tok_type  t;
   } idle_res_type;

   scan_type                  st_ff, st_in, s;
   logic                      done_ff, done_in;
   tok_type [MAX_RESULTS-1:0] toks;
   logic [1:0]                n;
   logic                      brk;
   idle_res_type              r;
   logic                      acc;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic scan_type consume(input scan_type x);
      scan_type y;
      y = x;
      if (x.p != {OFFSET_BITS{1'b1}}) y.p = x.p + 1'b1;
      if (x.cl != 16'hFFFF) y.cl = x.cl + 16'd1;
      return y;
   endfunction

   function automatic scan_type grow(input scan_type x);
      scan_type y;
      y = x;
      if (x.pl != 16'hFFFF) y.pl = x.pl + 16'd1;
      return y;
   endfunction

   function automatic tok_type mk(input scan_type x, input logic [OFFSET_BITS-1:0] start,
                                  input logic [15:0] len, input logic [6:0] kind);
      tok_type t;
      logic [OFFSET_BITS+23:0] ext;
      ext = {24'd0, start};
      t.kind = kind;
      t.start = ext[23:0];
      t.len = len;
      t.line = x.ln;
      t.col = (x.cl >= len) ? (x.cl - len) : 16'd0;
      return t;
   endfunction

   function automatic scan_type begin_tok(input scan_type x, input mode_type m);
      scan_type y;
      y = x;
      y.ps = x.p;
      y.pl = 16'd1;
      y = consume(y);
      y.mode = m;
      return y;
   endfunction

   function automatic idle_res_type scan_idle(input scan_type x, input logic [7:0] c);
      idle_res_type q;
      logic [6:0] single;
      q.s = x;
      q.v = 1'b0;
      q.t = '0;
      single = KD_ERROR;
      unique case (c)
         "(": single = KD_LPAREN;
         ")": single = KD_RPAREN;
         "{": single = KD_LBRACE;
         "}": single = KD_RBRACE;
         "[": single = KD_LBRACKET;
         "]": single = KD_RBRACKET;
         ";": single = KD_SEMI;
         ",": single = KD_COMMA;
         ".": single = KD_DOT;
         "+": single = KD_PLUS;
         "*": single = KD_STAR;
         "%": single = KD_PERCENT;
         "|": single = KD_PIPE;
         "&": single = KD_AMP;
         default: single = KD_ERROR;
      endcase
      priority if (c == " " || c == "\r" || c == "\t") begin
         q.s = consume(x);
      end else if (c == "\n") begin
         if (x.ln != 16'hFFFF) q.s.ln = x.ln + 16'd1;
         q.s.cl = 16'd0;
         q.s = consume(q.s);
      end else if (c == "\"") begin
         q.s = begin_tok(x, M_STR);
      end else if (c == "/") begin
         q.s = begin_tok(x, M_SLASH);
      end else if (c == ":") begin
         q.s = begin_tok(x, M_COLON);
      end else if (c == "-") begin
         q.s = begin_tok(x, M_MINUS);
      end else if (c == "=") begin
         q.s = begin_tok(x, M_EQ);
      end else if (c == "!") begin
         q.s = begin_tok(x, M_BANG);
      end else if (c == "<") begin
         q.s = begin_tok(x, M_LT);
      end else if (c == ">") begin
         q.s = begin_tok(x, M_GT);
      end else if (is_alpha(c) || c == "_") begin
         q.s = begin_tok(x, M_WORD);
         q.s.kb = KB_BITS'(c);
      end else if (is_digit(c)) begin
         q.s = begin_tok(x, M_INT);
      end else begin
         q.s = begin_tok(x, M_IDLE);
         q.v = 1'b1;
         q.t = mk(q.s, q.s.ps, q.s.pl, single);
      end
      return q;
   endfunction

   function automatic logic [6:0] op_kind(input mode_type m);
      logic [6:0] k;
      unique case (m)
         M_SLASH: k = KD_SLASH;
         M_COLON: k = KD_COLON;
         M_MINUS: k = KD_MINUS;
         M_EQ:    k = KD_EQ;
         M_BANG:  k = KD_BANG;
         M_LT:    k = KD_LT;
         M_GT:    k = KD_GT;
         default: k = KD_ERROR;
      endcase
      return k;
   endfunction

   assign req_ready = q_not_full;
   assign acc = req_valid && req_ready;

   always_comb begin
      s = st_ff;
      done_in = done_ff;
      toks = '0;
      n = 2'd0;
      brk = 1'b0;
      r = '0;
      if (done_ff) begin
         if (req_end_of_source) begin
            toks[n] = mk(s, s.p, 16'd0, KD_EOF);
            n = n + 2'd1;
         end
      end else if (req_end_of_source) begin
         unique case (s.mode)
            M_WORD: begin
               toks[n] = mk(s, s.ps, s.pl, KD_IDENT);
               n = n + 2'd1;
            end
            M_INT, M_FRAC: begin
               toks[n] = mk(s, s.ps, s.pl, KD_NUMBER);
               n = n + 2'd1;
            end
            M_DOT: begin
               toks[n] = mk(s, s.ps, s.pl, KD_NUMBER);
               n = n + 2'd1;
               r = scan_idle(s, ".");
               s = r.s;
               toks[n] = r.t;
               n = n + 2'd1;
            end
            M_STR: begin
               toks[n] = mk(s, s.ps, s.pl, KD_ERROR);
               n = n + 2'd1;
            end
            M_SLASH, M_COLON, M_MINUS, M_EQ, M_BANG, M_LT, M_GT: begin
               toks[n] = mk(s, s.ps, s.pl, op_kind(s.mode));
               n = n + 2'd1;
            end
            default: ;
         endcase
         s.mode = M_IDLE;
         toks[n] = mk(s, s.p, 16'd0, KD_EOF);
         n = n + 2'd1;
         done_in = 1'b1;
      end else begin
         unique case (s.mode)
            M_WORD: begin
               if (is_alpha(req_char_byte) || is_digit(req_char_byte)
                   || req_char_byte == "_") begin
                  if (s.pl < 16'(MAX_KEYWORD_CHARS))
                     s.kb = {s.kb[KB_BITS-9:0], req_char_byte};
                  s = grow(consume(s));
               end else begin
                  toks[n] = mk(s, s.ps, s.pl, KD_IDENT);
                  n = n + 2'd1;
                  s.mode = M_IDLE;
                  brk = 1'b1;
               end
            end
            M_INT: begin
               if (is_digit(req_char_byte)) begin
                  s = grow(consume(s));
               end else if (req_char_byte == ".") begin
                  s.mode = M_DOT;
               end else begin
                  toks[n] = mk(s, s.ps, s.pl, KD_NUMBER);
                  n = n + 2'd1;
                  s.mode = M_IDLE;
                  brk = 1'b1;
               end
            end
            M_DOT: begin
               if (is_digit(req_char_byte)) begin
                  s = grow(consume(grow(consume(s))));
                  s.mode = M_FRAC;
               end else begin
                  toks[n] = mk(s, s.ps, s.pl, KD_NUMBER);
                  n = n + 2'd1;
                  s.mode = M_IDLE;
                  r = scan_idle(s, ".");
                  s = r.s;
                  toks[n] = r.t;
                  n = n + 2'd1;
                  brk = 1'b1;
               end
            end
            M_FRAC: begin
               if (is_digit(req_char_byte)) begin
                  s = grow(consume(s));
               end else begin
                  toks[n] = mk(s, s.ps, s.pl, KD_NUMBER);
                  n = n + 2'd1;
                  s.mode = M_IDLE;
                  brk = 1'b1;
               end
            end
            M_STR: begin
               if (req_char_byte == "\n" && s.ln != 16'hFFFF) s.ln = s.ln + 16'd1;
               s = grow(consume(s));
               if (req_char_byte == "\"") begin
                  toks[n] = mk(s, s.ps, s.pl, KD_STRING);
                  n = n + 2'd1;
                  s.mode = M_IDLE;
               end
            end
            M_CMT: begin
               if (req_char_byte != "\n") begin
                  s = consume(s);
               end else begin
                  s.mode = M_IDLE;
                  brk = 1'b1;
               end
            end
            M_SLASH: begin
               if (req_char_byte == "/") begin
                  s = consume(s);
                  s.mode = M_CMT;
               end else begin
                  toks[n] = mk(s, s.ps, s.pl, KD_SLASH);
                  n = n + 2'd1;
                  s.mode = M_IDLE;
                  brk = 1'b1;
               end
            end
            M_COLON, M_MINUS, M_EQ, M_BANG, M_LT, M_GT: begin
               priority if (s.mode == M_COLON && req_char_byte == ":") begin
                  s = grow(consume(s));
                  toks[n] = mk(s, s.ps, s.pl, KD_DCOLON);
                  n = n + 2'd1;
                  s.mode = M_IDLE;
               end else if (s.mode == M_MINUS && req_char_byte == ">") begin
                  s = grow(consume(s));
                  toks[n] = mk(s, s.ps, s.pl, KD_ARROW);
                  n = n + 2'd1;
                  s.mode = M_IDLE;
               end else if (s.mode == M_EQ && req_char_byte == "=") begin
                  s = grow(consume(s));
                  toks[n] = mk(s, s.ps, s.pl, KD_EQEQ);
                  n = n + 2'd1;
                  s.mode = M_IDLE;
               end else if (s.mode == M_EQ && req_char_byte == ">") begin
                  s = grow(consume(s));
                  toks[n] = mk(s, s.ps, s.pl, KD_FATARROW);
                  n = n + 2'd1;
                  s.mode = M_IDLE;
               end else if (s.mode == M_BANG && req_char_byte == "=") begin
                  s = grow(consume(s));
                  toks[n] = mk(s, s.ps, s.pl, KD_BANGEQ);
                  n = n + 2'd1;
                  s.mode = M_IDLE;
               end else if (s.mode == M_LT && req_char_byte == "=") begin
                  s = grow(consume(s));
                  toks[n] = mk(s, s.ps, s.pl, KD_LE);
                  n = n + 2'd1;
                  s.mode = M_IDLE;
               end else if (s.mode == M_GT && req_char_byte == "=") begin
                  s = grow(consume(s));
                  toks[n] = mk(s, s.ps, s.pl, KD_GE);
                  n = n + 2'd1;
                  s.mode = M_IDLE;
               end else begin
                  toks[n] = mk(s, s.ps, s.pl, op_kind(s.mode));
                  n = n + 2'd1;
                  s.mode = M_IDLE;
                  brk = 1'b1;
               end
            end
            default: begin
               s.mode = M_IDLE;
               brk = 1'b1;
            end
         endcase
         if (brk) begin
            r = scan_idle(s, req_char_byte);
            s = r.s;
            if (r.v) begin
               toks[n] = r.t;
               n = n + 2'd1;
            end
         end
      end
   end

   assign st_in = acc ? s : st_ff;
   assign push = acc && (n != 2'd0);
   assign push_bundle.cnt = n;
   assign push_bundle.kw_code = KW_CODE_BITS'(st_ff.kb);
   assign push_bundle.tok = toks;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= '{mode: M_IDLE, kb: '0, pl: '0, ps: '0, p: '0, ln: 16'd1, cl: 16'd1};
         done_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (acc) done_ff <= done_in;
      end
   end

endmodule

>>> rtl/stl_queue.sv
// Short bundle queue between the front scanner and the back emitter.
// Uses stl_pkg for the bundle type and depth.
module stl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  stl_pkg::bundle_type push_bundle,
   input  logic                pop,
   output logic                not_full,
   output logic                not_empty,
   output stl_pkg::bundle_type head
);
   import stl_pkg::*;

   bundle_type                  mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QUEUE_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                        do_push, do_pop;

   assign not_full = cnt_ff != QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign do_push = push && not_full;
   assign do_pop = pop && not_empty;
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QUEUE_CNT_BITS'(do_push) - QUEUE_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_bundle;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> rtl/stl_back.sv
// Back emitter: walks the tokens of the head bundle, resolves keywords and
// holds one token beat in the output register. Uses stl_pkg.
module stl_back #(
   parameter int MAX_KEYWORD_CHARS = 7
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  stl_pkg::bundle_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [6:0]          rsp_token_kind,
   output logic [23:0]         rsp_start_offset,
   output logic [15:0]         rsp_token_length,
   output logic [15:0]         rsp_line_number,
   output logic [15:0]         rsp_column_number,
   output logic                rsp_last_of_run
);
   import stl_pkg::*;

   logic       valid_ff;
   logic [1:0] idx_ff, idx_in;
   tok_type    tok_ff, tok_in, cur;
   logic       last_ff, last_in;
   logic       load;

   assign load = not_empty && (!valid_ff || rsp_ready);

   always_comb begin
      cur = head.tok[idx_ff];
      tok_in = cur;
      if (cur.kind == KD_IDENT && cur.len <= 16'(MAX_KEYWORD_CHARS))
         tok_in.kind = kw_kind(head.kw_code);
      last_in = (idx_ff + 2'd1) == head.cnt;
      pop = load && last_in;
      idx_in = load ? (last_in ? 2'd0 : idx_ff + 2'd1) : idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
         if (load) valid_ff <= 1'b1;
         else if (rsp_ready) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff <= tok_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_token_kind = tok_ff.kind;
   assign rsp_start_offset = tok_ff.start;
   assign rsp_token_length = tok_ff.len;
   assign rsp_line_number = tok_ff.line;
   assign rsp_column_number = tok_ff.col;
   assign rsp_last_of_run = last_ff;

endmodule

>>> rtl/source_tokenizer_stream_top.sv
// Source tokenizer top level: front scanner, bundle queue and back emitter.
// Depends on stl_pkg, stl_front, stl_queue and stl_back.
//
// Takes one source byte (or the end marker) per cycle and returns tokens with
// kind, start offset, length, line and column; one input beat yields zero to
// three token beats, the last flagged by rsp_last_of_run. The scanner accepts
// one beat per clock while the four-entry bundle queue has room; the emitter
// sends one token per clock while rsp_ready is high, so a run of beats that each
// make several tokens is paced by the output at one token per cycle. The tokens
// of an accepted byte pass the bundle queue and then the output register.
module source_tokenizer_stream_top
   import stl_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT,
   parameter int MAX_KEYWORD_CHARS = MAX_KEYWORD_CHARS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_token_kind,
   output logic [23:0] rsp_start_offset,
   output logic [15:0] rsp_token_length,
   output logic [15:0] rsp_line_number,
   output logic [15:0] rsp_column_number,
   output logic        rsp_last_of_run
);

   logic       q_not_full, q_not_empty, push, pop;
   bundle_type push_bundle, head;

   stl_front #(
      .OFFSET_BITS(OFFSET_BITS),
      .MAX_KEYWORD_CHARS(MAX_KEYWORD_CHARS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_byte(req_char_byte),
      .req_end_of_source(req_end_of_source),
      .q_not_full(q_not_full),
      .push(push),
      .push_bundle(push_bundle)
   );

   stl_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_bundle(push_bundle),
      .pop(pop),
      .not_full(q_not_full),
      .not_empty(q_not_empty),
      .head(head)
   );

   stl_back #(
      .MAX_KEYWORD_CHARS(MAX_KEYWORD_CHARS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .not_empty(q_not_empty),
      .head(head),
      .pop(pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_token_kind(rsp_token_kind),
      .rsp_start_offset(rsp_start_offset),
      .rsp_token_length(rsp_token_length),
      .rsp_line_number(rsp_line_number),
      .rsp_column_number(rsp_column_number),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

>>> test/tb_source_tokenizer_stream_top.sv
// Testbench for source_tokenizer_stream_top: drives source text beats, predicts
// the token stream in a scanner model of its own and checks every token beat.
// Depends on stl_pkg and the tokenizer RTL.
module tb_source_tokenizer_stream_top;
   import stl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 320;

   typedef enum int {SC_IDLE, SC_WORD, SC_INT, SC_DOT, SC_FRAC, SC_STR, SC_CMT, SC_SLASH,
                     SC_COLON, SC_MINUS, SC_EQ, SC_BANG, SC_LT, SC_GT} scan_state_type;

   typedef struct {
      logic [6:0]  kind;
      logic [23:0] start;
      logic [15:0] len;
      logic [15:0] line;
      logic [15:0] col;
      logic        last;
   } token_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [7:0]  req_char_byte = 0;
   logic        req_end_of_source = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [6:0]  rsp_token_kind;
   logic [23:0] rsp_start_offset;
   logic [15:0] rsp_token_length;
   logic [15:0] rsp_line_number;
   logic [15:0] rsp_column_number;
   logic        rsp_last_of_run;

   source_tokenizer_stream_top dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   token_type      pending_tokens[$];
   token_type      beat_tokens[$];
   int             failures = 0;
   int             cycles = 0;
   int             beats_sent = 0;
   int             hold_off = 0;
   bit             no_idle = 0;

   scan_state_type mode = SC_IDLE;
   logic [55:0]    word_code = 0;
   int             tok_len = 0;
   logic [23:0]    tok_start = 0;
   logic [23:0]    offset = 0;
   int             line = 1;
   int             col = 1;
   bit             ended = 0;

   string       kw_text[40] = '{"fn","as","in","let","var","use","for","try","tag","else",
      "data","each","loop","next","open","flow","from","true","null","yield","abort",
      "check","match","while","cases","rules","skill","space","given","alias","async",
      "await","spawn","catch","false","expose","ensure","assert","require","derives"};
   int          kw_code[40] = '{8,36,28,18,19,34,27,40,16,24,9,26,29,33,20,13,35,5,7,31,
      32,23,25,30,10,11,12,14,15,17,37,38,39,41,6,21,43,44,42,22};
   string       op_text[24] = '{"(",")","{","}","[","]",";",":","::",",",".","+","-","->",
      "*","/","%","=","==","=>","!","!=","<=",">="};

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("source_tokenizer_stream_top test failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_off > 0) hold_off--;
   end

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic [6:0] word_kind();
      logic [63:0] code;
      if (tok_len > 7) return KD_IDENT;
      foreach (kw_text[i]) begin
         if (kw_text[i].len() != tok_len) continue;
         code = 0;
         for (int j = 0; j < kw_text[i].len(); j++) code = (code << 8) | kw_text[i][j];
         if (code == {8'd0, word_code}) return 7'(kw_code[i]);
      end
      return KD_IDENT;
   endfunction

   task automatic push_token(logic [6:0] kind, logic [23:0] start, int len);
      token_type t;
      if (beat_tokens.size() >= 3) return;
      t.kind = kind;
      t.start = start;
      t.len = 16'(len);
      t.line = 16'(line);
      t.col = (col >= len) ? 16'(col - len) : 16'd0;
      t.last = 0;
      beat_tokens.push_back(t);
   endtask

   task automatic close_token(logic [6:0] kind);
      push_token(kind, tok_start, tok_len);
      mode = SC_IDLE;
   endtask

   task automatic advance();
      if (offset != 24'hFFFFFF) offset++;
      if (col < 65535) col++;
   endtask

   task automatic extend();
      if (tok_len < 65535) tok_len++;
   endtask

   task automatic open_token(scan_state_type m);
      tok_start = offset;
      tok_len = 1;
      advance();
      mode = m;
   endtask

   task automatic pair_token(logic [6:0] kind);
      advance();
      extend();
      close_token(kind);
   endtask

   task automatic scan_fresh(logic [7:0] c);
      logic [6:0] single;
      single = KD_ERROR;
      case (c)
         " ", "\r", "\t": begin
            advance();
            return;
         end
         "\n": begin
            if (line < 65535) line++;
            col = 0;
            advance();
            return;
         end
         "\"": begin open_token(SC_STR); return; end
         "/": begin open_token(SC_SLASH); return; end
         ":": begin open_token(SC_COLON); return; end
         "-": begin open_token(SC_MINUS); return; end
         "=": begin open_token(SC_EQ); return; end
         "!": begin open_token(SC_BANG); return; end
         "<": begin open_token(SC_LT); return; end
         ">": begin open_token(SC_GT); return; end
         "(": single = KD_LPAREN;
         ")": single = KD_RPAREN;
         "{": single = KD_LBRACE;
         "}": single = KD_RBRACE;
         "[": single = KD_LBRACKET;
         "]": single = KD_RBRACKET;
         ";": single = KD_SEMI;
         ",": single = KD_COMMA;
         ".": single = KD_DOT;
         "+": single = KD_PLUS;
         "*": single = KD_STAR;
         "%": single = KD_PERCENT;
         "|": single = KD_PIPE;
         "&": single = KD_AMP;
         default: ;
      endcase
      if (is_alpha(c) || c == "_") begin
         open_token(SC_WORD);
         word_code = 56'(c);
         return;
      end
      if (is_digit(c)) begin
         open_token(SC_INT);
         return;
      end
      open_token(SC_IDLE);
      close_token(single);
   endtask

   task automatic scan_byte(logic [7:0] c);
      case (mode)
         SC_WORD: begin
            if (is_alpha(c) || is_digit(c) || c == "_") begin
               if (tok_len < 7) word_code = (word_code << 8) | c;
               advance();
               extend();
               return;
            end
            close_token(word_kind());
         end
         SC_INT: begin
            if (is_digit(c)) begin advance(); extend(); return; end
            if (c == ".") begin mode = SC_DOT; return; end
            close_token(KD_NUMBER);
         end
         SC_DOT: begin
            if (is_digit(c)) begin
               advance(); extend(); advance(); extend();
               mode = SC_FRAC;
               return;
            end
            close_token(KD_NUMBER);
            scan_fresh(".");
         end
         SC_FRAC: begin
            if (is_digit(c)) begin advance(); extend(); return; end
            close_token(KD_NUMBER);
         end
         SC_STR: begin
            if (c == "\n" && line < 65535) line++;
            advance();
            extend();
            if (c == "\"") close_token(KD_STRING);
            return;
         end
         SC_CMT: begin
            if (c != "\n") begin advance(); return; end
            mode = SC_IDLE;
         end
         SC_SLASH: begin
            if (c == "/") begin advance(); mode = SC_CMT; return; end
            close_token(KD_SLASH);
         end
         SC_COLON: begin
            if (c == ":") begin pair_token(KD_DCOLON); return; end
            close_token(KD_COLON);
         end
         SC_MINUS: begin
            if (c == ">") begin pair_token(KD_ARROW); return; end
            close_token(KD_MINUS);
         end
         SC_EQ: begin
            if (c == "=") begin pair_token(KD_EQEQ); return; end
            if (c == ">") begin pair_token(KD_FATARROW); return; end
            close_token(KD_EQ);
         end
         SC_BANG: begin
            if (c == "=") begin pair_token(KD_BANGEQ); return; end
            close_token(KD_BANG);
         end
         SC_LT: begin
            if (c == "=") begin pair_token(KD_LE); return; end
            close_token(KD_LT);
         end
         SC_GT: begin
            if (c == "=") begin pair_token(KD_GE); return; end
            close_token(KD_GT);
         end
         default: mode = SC_IDLE;
      endcase
      scan_fresh(c);
   endtask

   task automatic flush_pending();
      case (mode)
         SC_WORD: close_token(word_kind());
         SC_INT, SC_FRAC: close_token(KD_NUMBER);
         SC_DOT: begin close_token(KD_NUMBER); scan_fresh("."); end
         SC_STR: close_token(KD_ERROR);
         SC_SLASH: close_token(KD_SLASH);
         SC_COLON: close_token(KD_COLON);
         SC_MINUS: close_token(KD_MINUS);
         SC_EQ: close_token(KD_EQ);
         SC_BANG: close_token(KD_BANG);
         SC_LT: close_token(KD_LT);
         SC_GT: close_token(KD_GT);
         default: ;
      endcase
      mode = SC_IDLE;
   endtask

   task automatic predict_tokens(logic [7:0] c, logic eos);
      beat_tokens.delete();
      if (ended) begin
         if (eos) push_token(KD_EOF, offset, 0);
      end else if (eos) begin
         flush_pending();
         push_token(KD_EOF, offset, 0);
         ended = 1;
      end else begin
         scan_byte(c);
      end
      if (beat_tokens.size() > 0) beat_tokens[beat_tokens.size() - 1].last = 1;
      foreach (beat_tokens[i]) pending_tokens.push_back(beat_tokens[i]);
   endtask

   task automatic send_beat(logic [7:0] c, logic eos);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_char_byte = c;
      req_end_of_source = eos;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      predict_tokens(c, eos);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 0);
   endtask

   task automatic wait_drained();
      req_valid = 0;
      while (pending_tokens.size() > 0) @(negedge clock);
   endtask

   initial begin
      token_type e;
      int w;
      forever begin
         w = no_idle ? 0 : $urandom_range(0, 4);
         rsp_ready = 0;
         repeat (w) @(negedge clock);
         while (hold_off > 0) @(negedge clock);
         rsp_ready = 1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_tokens.size() == 0) begin
            $error("token beat with nothing expected: kind %0d", rsp_token_kind);
            failures++;
         end else begin
            e = pending_tokens.pop_front();
            if (rsp_token_kind !== e.kind) begin
               $error("token_kind expected %0d actual %0d", e.kind, rsp_token_kind);
               failures++;
            end
            if (rsp_start_offset !== e.start) begin
               $error("start_offset expected %0d actual %0d", e.start, rsp_start_offset);
               failures++;
            end
            if (rsp_token_length !== e.len) begin
               $error("token_length expected %0d actual %0d", e.len, rsp_token_length);
               failures++;
            end
            if (rsp_line_number !== e.line) begin
               $error("line_number expected %0d actual %0d", e.line, rsp_line_number);
               failures++;
            end
            if (rsp_column_number !== e.col) begin
               $error("column_number expected %0d actual %0d", e.col, rsp_column_number);
               failures++;
            end
            if (rsp_last_of_run !== e.last) begin
               $error("last_of_run expected %0d actual %0d", e.last, rsp_last_of_run);
               failures++;
            end
         end
         @(negedge clock);
      end
   end

   task automatic test_directed_tokens();
      send_text("fn derives x_9 ");
      send_text("12.5 7.a 3.");
      send_text("\n:: -> => == != <= >= ;");
      send_beat(8'h00, 0);
      send_beat(8'hFF, 0);
      send_text("\"a\nb\"/ //c\n");
   endtask

   task automatic send_random_token();
      int n;
      string s;
      case ($urandom_range(0, 9))
         0, 1: send_text(kw_text[$urandom_range(0, 39)]);
         2: begin
            n = $urandom_range(1, 10);
            s = "";
            for (int i = 0; i < n; i++)
               case ($urandom_range(0, 3))
                  0: s = {s, string'(8'($urandom_range("a", "z")))};
                  1: s = {s, string'(8'($urandom_range("A", "Z")))};
                  2: s = {s, i == 0 ? "_" : string'(8'($urandom_range("0", "9")))};
                  default: s = {s, "_"};
               endcase
            send_text(s);
         end
         3: begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) send_beat(8'($urandom_range("0", "9")), 0);
            if ($urandom_range(0, 1)) begin
               send_beat(".", 0);
               if ($urandom_range(0, 2) != 0) send_beat(8'($urandom_range("0", "9")), 0);
            end
         end
         4: begin
            send_beat("\"", 0);
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
               w_byte: begin
                  logic [7:0] b;
                  b = $urandom_range(0, 3) == 0 ? 8'h0A : 8'($urandom_range(0, 255));
                  if (b == "\"") b = "q";
                  send_beat(b, 0);
               end
            end
            send_beat("\"", 0);
         end
         5: begin
            send_text("//");
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) send_beat(8'($urandom_range(32, 126)), 0);
            send_beat("\n", 0);
         end
         6, 7: send_text(op_text[$urandom_range(0, 23)]);
         default: send_beat(8'($urandom_range(0, 255)), 0);
      endcase
      case ($urandom_range(0, 5))
         0: send_beat("\n", 0);
         1: send_beat("\t", 0);
         2: send_beat("\r", 0);
         3: ;
         default: send_beat(" ", 0);
      endcase
   endtask

   task automatic test_random_text();
      int goal;
      goal = beats_sent + RANDOM_ITEMS;
      while (beats_sent < goal) begin
         no_idle = ($urandom_range(0, 7) == 0);
         repeat ($urandom_range(1, 6)) send_random_token();
      end
      no_idle = 0;
   endtask

   task automatic test_backpressure();
      wait_drained();
      hold_off = 80;
      no_idle = 1;
      repeat (12) send_text("1.+");
      no_idle = 0;
      wait_drained();
   endtask

   task automatic test_end_of_source();
      send_text(" \"open");
      send_beat(8'h00, 1);
      send_beat("a", 0);
      send_beat(8'hFF, 1);
      send_beat(8'h00, 1);
   endtask

   initial begin
      int settle;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;
      test_directed_tokens();
      test_backpressure();
      test_random_text();
      test_end_of_source();
      wait_drained();
      settle = 0;
      while (settle < 20) begin
         @(negedge clock);
         settle++;
      end
      if (failures == 0 && pending_tokens.size() == 0) begin
         $display("source_tokenizer_stream_top test passed");
      end else begin
         $display("source_tokenizer_stream_top test failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/stl_pkg.sv
rtl/stl_front.sv
rtl/stl_queue.sv
rtl/stl_back.sv
rtl/source_tokenizer_stream_top.sv
test/tb_source_tokenizer_stream_top.sv
